FILE: design/cbs_pkg.sv
// Shared types and constants for the cubic B-spline curve sampler.
// No dependencies; imported by the top level, cbs_ctrl and cbs_datapath.
package cbs_pkg;

    localparam int COORD_W = 24;
    localparam int REG_W   = 7;
    localparam int T_W     = 7;
    localparam int W_W     = 32;
    localparam int PROD_W  = W_W + COORD_W;
    localparam int ACC_W   = 60;
    localparam int DEN_W   = 24;
    localparam int QUO_W   = COORD_W + 1;
    localparam int STEP_W  = 5;
    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SPLIT_COUNT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POINTS_PER_SEG = 4'd1;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

    // Datapath operations
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_TAKE  = 3'd1;
    localparam logic [2:0] OP_WGT   = 3'd2;
    localparam logic [2:0] OP_MAC   = 3'd3;
    localparam logic [2:0] OP_DPREP = 3'd4;
    localparam logic [2:0] OP_DIV   = 3'd5;
    localparam logic [2:0] OP_DFIN  = 3'd6;
    localparam logic [2:0] OP_SHIFT = 3'd7;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic                      start_curve;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic                      last_of_segment;
    } t_out_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_vec3;

    typedef struct packed {
        logic [2:0]        op;
        logic [STEP_W-1:0] step;
        logic [1:0]        coord;
        logic [T_W-1:0]    t;
        logic              last;
    } t_dp_cmd;

    typedef struct packed {
        logic segment;
    } t_dp_status;

    function automatic logic signed [COORD_W-1:0] pick_coord(input t_vec3 v,
                                                             input logic [1:0] c);
        logic signed [COORD_W-1:0] r;
        unique case (c)
            2'd0:    r = v.x;
            2'd1:    r = v.y;
            default: r = v.z;
        endcase
        return r;
    endfunction

endpackage

FILE: design/cubic_bspline_curve_sampler_unit.sv
// Top level of the uniform cubic B-spline curve sampler.
// Depends on cbs_pkg, cbs_ctrl and cbs_datapath.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall, i_in_data) carries control
//   points in signed Q8.16. A transfer with start_curve set clears the
//   window. The first three points of a curve only fill the window; each
//   later point closes a segment and yields points_per_segment results.
//   Output channel (o_out_valid / i_out_stall, o_out_data) returns curve
//   points, last_of_segment marking the final one of each segment.
//   Config port (i_cfg_valid / o_cfg_ready) is always ready; index 0 is
//   split_count, index 1 points_per_segment, other indexes are dropped.
//   Write configuration only while the block is idle.
// Sequencing:
//   A window-filling point is taken straight from idle. Each curve point
//   runs the weight steps, then for each of x, y and z the multiply-
//   accumulate steps and the shared bit-serial rounding divider, then its
//   result transfer. One point is processed at a time; o_in_stall stays
//   high until the segment's last result transfers.
// Reset (synchronous, active low) returns the registers to 16 and 16, empties
// the window and drops any work in flight. A stalled receiver simply holds
// the current result and the controller waits.
module cubic_bspline_curve_sampler_unit #(
    parameter int MAX_POINTS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  cbs_pkg::t_in_item                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output cbs_pkg::t_out_item                  o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cbs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [cbs_pkg::REG_W-1:0]           i_cfg_data
);
    import cbs_pkg::*;

    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    logic [REG_W-1:0] r_split, r_pps;
    logic [REG_W-1:0] split_eff;
    logic [CW-1:0]    count;
    t_dp_cmd          cmd;
    t_dp_status       status;

    assign o_cfg_ready = 1'b1;

    // Hold the configuration registers; ignore indexes beyond the list.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_split <= 7'd16;
            r_pps   <= 7'd16;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_SPLIT_COUNT)    r_split <= i_cfg_data;
            if (i_cfg_index == REG_POINTS_PER_SEG) r_pps   <= i_cfg_data;
        end
    end

    // A zero step count behaves as one.
    assign split_eff = (r_split == '0) ? 7'd1 : r_split;

    // Clamp the per-segment count to 1..MAX_POINTS.
    always_comb begin
        priority if (r_pps == '0)                count = CW'(1);
        else if (r_pps > REG_W'(MAX_POINTS))     count = CW'(MAX_POINTS);
        else                                     count = CW'(r_pps);
    end

    cbs_ctrl #(
        .MAX_POINTS (MAX_POINTS),
        .IW         (IW),
        .CW         (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_count     (count),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    cbs_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_point  (i_in_data),
        .i_split  (split_eff),
        .o_status (status),
        .o_result (o_out_data)
    );

endmodule

FILE: design/cbs_datapath.sv
// Datapath: control point window, basis weights, multiply-accumulate and
// bit-serial rounding divider. Depends on cbs_pkg; driven by cbs_ctrl.
module cbs_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  cbs_pkg::t_dp_cmd           i_cmd,
    input  cbs_pkg::t_in_item          i_point,
    input  logic [cbs_pkg::REG_W-1:0]  i_split,
    output cbs_pkg::t_dp_status        o_status,
    output cbs_pkg::t_out_item         o_result
);
    import cbs_pkg::*;

    t_vec3 r_hist [0:2];
    t_vec3 r_p3;
    logic [1:0] r_fill;

    logic [13:0] r_s2, r_t2, r_ts;
    logic signed [7:0]  r_d;
    logic [20:0] r_s3, r_t3, r_t2s, r_ts2;
    logic signed [15:0] r_d2;
    logic signed [W_W-1:0] r_w [0:3];
    logic [DEN_W-1:0] r_den;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]         r_rem;
    logic [QUO_W-1:0]         r_quo;
    logic                     r_neg;
    t_out_item                r_out;

    t_vec3 in_vec;
    logic  store_hist;
    logic [1:0] widx;
    logic signed [W_W-1:0] t3e, t2se, s3e, ts2e;
    logic signed [COORD_W-1:0] h_sel;
    logic signed [W_W-1:0]     w_sel;
    logic [1:0] mk;
    logic [4:0] dk;
    logic [ACC_W-1:0] trial, mag;
    logic signed [COORD_W-1:0] res;

    assign in_vec     = '{x: i_point.point_x, y: i_point.point_y, z: i_point.point_z};
    assign store_hist = i_point.start_curve || (r_fill != 2'd3);
    assign widx       = i_point.start_curve ? 2'd0 : r_fill;
    assign o_status.segment = !i_point.start_curve && (r_fill == 2'd3);

    assign t3e  = W_W'($signed({1'b0, r_t3}));
    assign t2se = W_W'($signed({1'b0, r_t2s}));
    assign s3e  = W_W'($signed({1'b0, r_s3}));
    assign ts2e = W_W'($signed({1'b0, r_ts2}));

    assign mk = i_cmd.step[1:0];
    always_comb begin
        priority if (mk == 2'd3) h_sel = pick_coord(r_p3, i_cmd.coord);
        else                     h_sel = pick_coord(r_hist[mk], i_cmd.coord);
        w_sel = r_w[mk];
    end

    assign dk    = 5'(5'd25 - i_cmd.step);
    assign trial = ACC_W'(r_den) << dk;
    assign mag   = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);

    always_comb begin
        priority if (r_quo[QUO_W-1] || (!r_neg && r_quo[COORD_W-1])) begin
            res = r_neg ? COORD_MIN : COORD_MAX;
        end else if (r_neg && r_quo[COORD_W-1] && (r_quo[COORD_W-2:0] != '0)) begin
            res = COORD_MIN;
        end else if (r_neg) begin
            res = $signed(~r_quo[COORD_W-1:0] + 24'd1);
        end else begin
            res = $signed(r_quo[COORD_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= 2'd0;
        end else if (i_cmd.op == OP_TAKE && store_hist) begin
            r_fill <= i_point.start_curve ? 2'd1 : 2'(r_fill + 2'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_TAKE: begin
                if (store_hist) begin
                    for (int k = 0; k < 3; k++) begin
                        if (widx == 2'(k)) r_hist[k] <= in_vec;
                    end
                end else begin
                    r_p3 <= in_vec;
                end
            end
            OP_SHIFT: begin
                r_hist[0] <= r_hist[1];
                r_hist[1] <= r_hist[2];
                r_hist[2] <= r_p3;
            end
            OP_WGT: begin
                unique case (i_cmd.step[1:0])
                    2'd0: begin
                        r_s2 <= 14'(i_split * i_split);
                        r_t2 <= 14'(i_cmd.t * i_cmd.t);
                        r_ts <= 14'(i_cmd.t * i_split);
                        r_d  <= $signed({1'b0, i_split}) - $signed({1'b0, i_cmd.t});
                    end
                    2'd1: begin
                        r_s3  <= 21'(r_s2 * 21'(i_split));
                        r_t3  <= 21'(r_t2 * 21'(i_cmd.t));
                        r_t2s <= 21'(r_t2 * 21'(i_split));
                        r_ts2 <= 21'(r_ts * 21'(i_split));
                        r_d2  <= 16'(r_d * r_d);
                    end
                    default: begin
                        r_w[0] <= W_W'(r_d2 * r_d);
                        r_w[1] <= 32'sd3 * t3e - 32'sd6 * t2se + 32'sd4 * s3e;
                        r_w[2] <= -(32'sd3 * t3e) + 32'sd3 * t2se + 32'sd3 * ts2e + s3e;
                        r_w[3] <= t3e;
                        r_den  <= DEN_W'({3'b0, r_s3} * 24'd6);
                    end
                endcase
            end
            OP_MAC: begin
                if (i_cmd.step < 5'd4) r_prod <= w_sel * h_sel;
                if (i_cmd.step == 5'd1)
                    r_acc <= ACC_W'(r_prod);
                else if (i_cmd.step != 5'd0)
                    r_acc <= r_acc + ACC_W'(r_prod);
            end
            OP_DPREP: begin
                r_neg <= r_acc[ACC_W-1];
                r_rem <= mag + ACC_W'(r_den >> 1);
                r_quo <= '0;
            end
            OP_DIV: begin
                if (r_rem >= trial) begin
                    r_rem     <= r_rem - trial;
                    r_quo[dk] <= 1'b1;
                end
            end
            OP_DFIN: begin
                unique case (i_cmd.coord)
                    2'd0:    r_out.out_x <= res;
                    2'd1:    r_out.out_y <= res;
                    default: r_out.out_z <= res;
                endcase
                r_out.last_of_segment <= i_cmd.last;
            end
            default: ;
        endcase
    end

    assign o_result = r_out;

endmodule

FILE: design/cbs_ctrl.sv
// Controller state machine: sequences weights, accumulation, division and
// result handshake per curve point. Depends on cbs_pkg.
module cbs_ctrl #(
    parameter int MAX_POINTS = 64,
    parameter int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
    parameter int CW = $clog2(MAX_POINTS + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_stall,
    input  logic [CW-1:0]       i_count,
    input  cbs_pkg::t_dp_status i_status,
    output cbs_pkg::t_dp_cmd    o_cmd,
    output logic                o_in_stall,
    output logic                o_out_valid
);
    import cbs_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WGT  = 3'd1;
    localparam logic [2:0] S_MAC  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic [1:0]        r_coord, n_coord;
    logic [IW-1:0]     r_i, n_i;
    logic              is_last;

    assign is_last = (CW'(r_i) + CW'(1)) == i_count;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_coord = r_coord;
        n_i     = r_i;
        o_cmd   = '{op: OP_NONE, step: r_step, coord: r_coord,
                    t: T_W'(r_i), last: is_last};
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_TAKE;
                    if (i_status.segment) begin
                        n_state = S_WGT;
                        n_step  = '0;
                        n_i     = '0;
                    end
                end
            end
            S_WGT: begin
                o_cmd.op = OP_WGT;
                n_step   = STEP_W'(r_step + 1'b1);
                if (r_step == 5'd2) begin
                    n_state = S_MAC;
                    n_step  = '0;
                    n_coord = 2'd0;
                end
            end
            S_MAC: begin
                o_cmd.op = OP_MAC;
                n_step   = STEP_W'(r_step + 1'b1);
                if (r_step == 5'd4) begin
                    n_state = S_DIV;
                    n_step  = '0;
                end
            end
            S_DIV: begin
                n_step = STEP_W'(r_step + 1'b1);
                priority if (r_step == 5'd0) begin
                    o_cmd.op = OP_DPREP;
                end else if (r_step == 5'd26) begin
                    o_cmd.op = OP_DFIN;
                    n_step   = '0;
                    if (r_coord == 2'd2) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_MAC;
                        n_coord = 2'(r_coord + 2'd1);
                    end
                end else begin
                    o_cmd.op = OP_DIV;
                end
            end
            S_EMIT: begin
                if (!i_out_stall) begin
                    if (is_last) begin
                        o_cmd.op = OP_SHIFT;
                        n_state  = S_IDLE;
                    end else begin
                        n_i     = IW'(r_i + 1'b1);
                        n_state = S_WGT;
                        n_step  = '0;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_coord <= '0;
            r_i     <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_coord <= n_coord;
            r_i     <= n_i;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);

endmodule

FILE: design/cbs_checker.sv
// Port-level checks for the curve sampler, bound to the top level.
// Depends on cubic_bspline_curve_sampler_unit ports only.
module cbs_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_cfg_ready
);

    // A pending result blocks new input transfers.
    a_stall_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input accepted while a result is pending");

    // A stalled result is not withdrawn.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped under stall");

    // Reset leaves no result pending and the input open.
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("state not cleared by reset");

    // Config port never stalls.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config port not ready");

endmodule

bind cubic_bspline_curve_sampler_unit cbs_checker u_cbs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_cfg_ready (o_cfg_ready)
);
